// ===== hw/rtl/pipmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pipmd_pkg
// Shared types, codes and constants of the PI position motor drive block.
// ----------------------------------------------------------------------------
package pipmd_pkg;

  localparam int unsigned TIMEOUT_TICKS_DEF = 2000;

  localparam int unsigned POS_W     = 24;
  localparam int unsigned ERR_W     = POS_W + 1;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned ISUM_W    = LIMIT_W + 1;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned SS_W      = 10;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned BRAKE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned PROD_W    = GAIN_W + 1 + ERR_W;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned IN_W      = 48;
  localparam int unsigned OUT_W     = 16;

  // ramp quotient never exceeds the duty span, so seven quotient bits suffice
  localparam int unsigned DIV_STEPS = DUTY_W;
  localparam int unsigned DIV_IDX_W = $clog2(DIV_STEPS);
  localparam int unsigned RAMP_W    = 17;

  localparam logic [GAIN_W-1:0]  KP_GAIN_RST      = 32'd838861;
  localparam logic [GAIN_W-1:0]  KI_GAIN_DT_RST   = 32'd1678;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIM_RST = 20'd100000;
  localparam logic [DUTY_W-1:0]  MIN_DUTY_RST     = 7'd100;
  localparam logic [DUTY_W-1:0]  MAX_DUTY_RST     = 7'd100;
  localparam logic [SS_W-1:0]    SOFTSTART_RST    = 10'd10;
  localparam logic [TOL_W-1:0]   STOP_TOL_RST     = 16'd25;
  localparam logic [BRAKE_W-1:0] BRAKE_TICKS_RST  = 8'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KI_GAIN_DT      = 3'd1,
    REG_INTEGRAL_LIMIT  = 3'd2,
    REG_MIN_DUTY        = 3'd3,
    REG_MAX_DUTY        = 3'd4,
    REG_SOFTSTART_TICKS = 3'd5,
    REG_STOP_TOLERANCE  = 3'd6,
    REG_BRAKE_TICKS     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_BRAKE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DRV_COAST = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_REV   = 2'd2,
    DRV_BRAKE = 2'd3
  } drive_t;

  typedef enum logic [2:0] {
    RS_IDLE    = 3'd0,
    RS_RUNNING = 3'd1,
    RS_BRAKING = 3'd2,
    RS_DONE    = 3'd3,
    RS_TIMEOUT = 3'd4
  } run_status_t;

  typedef enum logic [2:0] {
    DEC_START,
    DEC_BRAKE_STEP,
    DEC_IDLE,
    DEC_TIMEOUT,
    DEC_ARRIVE,
    DEC_DRIVE
  } dec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_EVAL,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC,
    ST_DIV,
    ST_DUTY,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic                 load;
    logic                 calc_err;
    logic                 eval;
    logic                 mul_p;
    logic                 mul_i;
    logic                 acc_add;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 duty;
    logic                 emit;
  } cmd_t;

  typedef struct packed {
    logic drive_path;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/pipmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pipmd_ctrl
// Sequencer of the motor drive: runs error and decision for every request,
// multiply, ramp divide and duty for a driving tick, and hands out the result.
// ----------------------------------------------------------------------------
module pipmd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  pipmd_pkg::stat_t stat,
  output pipmd_pkg::cmd_t  cmd
);

  localparam logic [pipmd_pkg::DIV_IDX_W-1:0] DIV_LAST =
    pipmd_pkg::DIV_IDX_W'(pipmd_pkg::DIV_STEPS - 1);

  pipmd_pkg::ctrl_state_t state, state_next;
  logic [pipmd_pkg::DIV_IDX_W-1:0] step_idx, step_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pipmd_pkg::ST_IDLE;
      step_idx <= '0;
    end else begin
      state    <= state_next;
      step_idx <= step_idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_idx_next = step_idx;
    cmd           = '0;
    cmd.div_idx   = step_idx;
    s_axis_tready = 1'b0;
    unique case (state)
      pipmd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = pipmd_pkg::ST_ERR;
        end
      end
      pipmd_pkg::ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = pipmd_pkg::ST_EVAL;
      end
      pipmd_pkg::ST_EVAL: begin
        cmd.eval      = 1'b1;
        step_idx_next = DIV_LAST;
        state_next    = stat.drive_path ? pipmd_pkg::ST_MUL_P : pipmd_pkg::ST_OUT;
      end
      pipmd_pkg::ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = pipmd_pkg::ST_MUL_I;
      end
      pipmd_pkg::ST_MUL_I: begin
        cmd.mul_i  = 1'b1;
        state_next = pipmd_pkg::ST_ACC;
      end
      pipmd_pkg::ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = pipmd_pkg::ST_DIV;
      end
      pipmd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_idx == '0) begin
          state_next = pipmd_pkg::ST_DUTY;
        end else begin
          step_idx_next = step_idx - 1'b1;
        end
      end
      pipmd_pkg::ST_DUTY: begin
        cmd.duty   = 1'b1;
        state_next = pipmd_pkg::ST_OUT;
      end
      pipmd_pkg::ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = pipmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pipmd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pipmd_datapath.sv =====
// ----------------------------------------------------------------------------
// pipmd_datapath
// Settings, move state, shared gain multiplier, soft-start ramp divider,
// duty shaping and the output register of the motor drive.
// ----------------------------------------------------------------------------
module pipmd_datapath #(
  parameter int unsigned TIMEOUT_TICKS = pipmd_pkg::TIMEOUT_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_kind,
  input  logic [pipmd_pkg::IN_W-1:0]      in_data,
  input  logic                            cfg_we,
  input  logic [pipmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pipmd_pkg::CFG_W-1:0]     cfg_data,
  input  pipmd_pkg::cmd_t                 cmd,
  output pipmd_pkg::stat_t                stat,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pipmd_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int unsigned EW = $clog2(TIMEOUT_TICKS + 1);
  localparam int unsigned CW = (EW > pipmd_pkg::SS_W) ? EW : pipmd_pkg::SS_W;
  localparam logic [EW-1:0] TIMEOUT_VAL = EW'(TIMEOUT_TICKS);
  localparam int unsigned POS_W  = pipmd_pkg::POS_W;
  localparam int unsigned ERR_W  = pipmd_pkg::ERR_W;
  localparam int unsigned ISUM_W = pipmd_pkg::ISUM_W;
  localparam int unsigned PROD_W = pipmd_pkg::PROD_W;
  localparam int unsigned DUTY_W = pipmd_pkg::DUTY_W;
  localparam int unsigned RAMP_W = pipmd_pkg::RAMP_W;
  localparam int unsigned SUM_W  = ERR_W + 1;
  localparam int unsigned SAT_LO = pipmd_pkg::FRAC_W + DUTY_W;

  // settings
  logic [pipmd_pkg::GAIN_W-1:0]  kp_gain, ki_gain_dt;
  logic [pipmd_pkg::LIMIT_W-1:0] integral_limit;
  logic [DUTY_W-1:0]             min_duty, max_duty;
  logic [pipmd_pkg::SS_W-1:0]    softstart_ticks;
  logic [pipmd_pkg::TOL_W-1:0]   stop_tolerance;
  logic [pipmd_pkg::BRAKE_W-1:0] brake_ticks;

  // move state
  pipmd_pkg::mode_t              mode;
  logic signed [POS_W-1:0]       move_target;
  logic signed [ISUM_W-1:0]      error_sum;
  logic [EW-1:0]                 elapsed;
  logic [pipmd_pkg::BRAKE_W-1:0] brake_left;

  // working registers
  logic                       in_kind_q;
  logic signed [POS_W-1:0]    in_val;
  logic signed [ERR_W-1:0]    err_q;
  logic signed [PROD_W-1:0]   prod, acc;
  logic [RAMP_W-1:0]          div_rem;
  logic [DUTY_W-1:0]          div_quo;
  logic                       div_neg;
  logic                       ramp_on;
  pipmd_pkg::drive_t          res_drive;
  logic [DUTY_W-1:0]          res_duty;
  pipmd_pkg::run_status_t     res_status;

  // combinational terms
  logic signed [ERR_W-1:0]    err_next;
  logic [ERR_W-1:0]           mag_err;
  logic                       near;
  logic signed [SUM_W-1:0]    sum_raw, lim_pos, sum_clamp;
  logic [CW-1:0]              elapsed_w;
  logic                       timed_out, ramp_now;
  logic [pipmd_pkg::BRAKE_W-1:0] left_dec;
  pipmd_pkg::dec_t            dec;
  logic signed [DUTY_W:0]     span;
  logic signed [RAMP_W+1:0]   ramp_prod;
  logic [RAMP_W-1:0]          ramp_mag;
  logic [RAMP_W-1:0]          div_sub;
  logic [pipmd_pkg::GAIN_W-1:0] mul_a;
  logic signed [ERR_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_out;
  logic [PROD_W-1:0]          acc_mag;
  logic [DUTY_W-1:0]          duty_floor, ceil_duty, duty_val;
  logic signed [DUTY_W+1:0]   quo_s, ceil9;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= pipmd_pkg::KP_GAIN_RST;
      ki_gain_dt      <= pipmd_pkg::KI_GAIN_DT_RST;
      integral_limit  <= pipmd_pkg::INTEGRAL_LIM_RST;
      min_duty        <= pipmd_pkg::MIN_DUTY_RST;
      max_duty        <= pipmd_pkg::MAX_DUTY_RST;
      softstart_ticks <= pipmd_pkg::SOFTSTART_RST;
      stop_tolerance  <= pipmd_pkg::STOP_TOL_RST;
      brake_ticks     <= pipmd_pkg::BRAKE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (pipmd_pkg::cfg_reg_t'(cfg_index))
        pipmd_pkg::REG_KP_GAIN:         kp_gain         <= cfg_data;
        pipmd_pkg::REG_KI_GAIN_DT:      ki_gain_dt      <= cfg_data;
        pipmd_pkg::REG_INTEGRAL_LIMIT:  integral_limit  <= cfg_data[pipmd_pkg::LIMIT_W-1:0];
        pipmd_pkg::REG_MIN_DUTY:        min_duty        <= cfg_data[DUTY_W-1:0];
        pipmd_pkg::REG_MAX_DUTY:        max_duty        <= cfg_data[DUTY_W-1:0];
        pipmd_pkg::REG_SOFTSTART_TICKS: softstart_ticks <= cfg_data[pipmd_pkg::SS_W-1:0];
        pipmd_pkg::REG_STOP_TOLERANCE:  stop_tolerance  <= cfg_data[pipmd_pkg::TOL_W-1:0];
        pipmd_pkg::REG_BRAKE_TICKS:     brake_ticks     <= cfg_data[pipmd_pkg::BRAKE_W-1:0];
        default: ;
      endcase
    end
  end

  // error and decision
  always_comb begin
    err_next  = $signed({move_target[POS_W-1], move_target})
              - $signed({in_val[POS_W-1], in_val});
    mag_err   = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
    near      = mag_err < ERR_W'(stop_tolerance);
    sum_raw   = $signed({{(SUM_W-ISUM_W){error_sum[ISUM_W-1]}}, error_sum})
              + $signed({err_q[ERR_W-1], err_q});
    lim_pos   = $signed(SUM_W'(integral_limit));
    if (sum_raw > lim_pos) begin
      sum_clamp = lim_pos;
    end else if (sum_raw < -lim_pos) begin
      sum_clamp = -lim_pos;
    end else begin
      sum_clamp = sum_raw;
    end
    elapsed_w = CW'(elapsed);
    timed_out = elapsed >= TIMEOUT_VAL;
    ramp_now  = elapsed_w < CW'(softstart_ticks);
    left_dec  = brake_left - pipmd_pkg::BRAKE_W'(brake_left != '0);

    if (in_kind_q == pipmd_pkg::KIND_START) begin
      dec = pipmd_pkg::DEC_START;
    end else if (mode == pipmd_pkg::MODE_BRAKE) begin
      dec = pipmd_pkg::DEC_BRAKE_STEP;
    end else if (mode != pipmd_pkg::MODE_RUN) begin
      dec = pipmd_pkg::DEC_IDLE;
    end else if (timed_out) begin
      dec = pipmd_pkg::DEC_TIMEOUT;
    end else if (near) begin
      dec = pipmd_pkg::DEC_ARRIVE;
    end else begin
      dec = pipmd_pkg::DEC_DRIVE;
    end
  end

  // soft-start ramp dividend and one restoring step
  always_comb begin
    span      = $signed({1'b0, max_duty}) - $signed({1'b0, min_duty});
    ramp_prod = span * $signed({1'b0, elapsed_w[pipmd_pkg::SS_W-1:0]});
    ramp_mag  = ramp_prod[RAMP_W+1] ? RAMP_W'(-ramp_prod) : RAMP_W'(ramp_prod);
    div_sub   = RAMP_W'(softstart_ticks) << cmd.div_idx;
  end

  // shared gain multiplier
  always_comb begin
    mul_a   = cmd.mul_i ? ki_gain_dt : kp_gain;
    mul_b   = cmd.mul_i ? $signed({{(ERR_W-ISUM_W){error_sum[ISUM_W-1]}}, error_sum})
                        : err_q;
    mul_out = $signed({1'b0, mul_a}) * mul_b;
  end

  // duty shaping
  always_comb begin
    acc_mag = acc[PROD_W-1] ? PROD_W'(-acc) : PROD_W'(acc);
    if (acc_mag[PROD_W-1:SAT_LO] != '0) begin
      duty_floor = '1;
    end else if (acc_mag[SAT_LO-1:pipmd_pkg::FRAC_W] < min_duty) begin
      duty_floor = min_duty;
    end else begin
      duty_floor = acc_mag[SAT_LO-1:pipmd_pkg::FRAC_W];
    end
    quo_s     = div_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    ceil9     = $signed({2'b00, min_duty}) + quo_s;
    ceil_duty = ramp_on ? ceil9[DUTY_W-1:0] : max_duty;
    duty_val  = (duty_floor > ceil_duty) ? ceil_duty : duty_floor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= pipmd_pkg::MODE_IDLE;
      move_target  <= '0;
      error_sum    <= '0;
      elapsed      <= '0;
      brake_left   <= '0;
    end else if (cmd.eval) begin
      unique case (dec)
        pipmd_pkg::DEC_START: begin
          move_target  <= in_val;
          error_sum    <= '0;
          elapsed      <= '0;
          brake_left   <= '0;
          mode         <= pipmd_pkg::MODE_RUN;
        end
        pipmd_pkg::DEC_BRAKE_STEP: begin
          brake_left <= left_dec;
          if (left_dec == '0) begin
            mode <= pipmd_pkg::MODE_IDLE;
          end
        end
        pipmd_pkg::DEC_IDLE, pipmd_pkg::DEC_TIMEOUT: begin
          mode <= pipmd_pkg::MODE_IDLE;
        end
        pipmd_pkg::DEC_ARRIVE: begin
          brake_left <= brake_ticks;
          mode       <= (brake_ticks == '0) ? pipmd_pkg::MODE_IDLE : pipmd_pkg::MODE_BRAKE;
        end
        pipmd_pkg::DEC_DRIVE: begin
          error_sum <= sum_clamp[ISUM_W-1:0];
        end
        default: ;
      endcase
    end else if (cmd.duty) begin
      elapsed <= elapsed + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_kind_q <= in_kind;
      in_val    <= (in_kind == pipmd_pkg::KIND_TICK) ? in_data[2*POS_W-1:POS_W]
                                                     : in_data[POS_W-1:0];
    end
    if (cmd.calc_err) begin
      err_q <= err_next;
    end
    if (cmd.eval) begin
      ramp_on <= ramp_now;
      div_rem <= ramp_mag;
      div_neg <= ramp_prod[RAMP_W+1];
      div_quo <= '0;
      res_duty <= '0;
      unique case (dec)
        pipmd_pkg::DEC_START: begin
          res_drive  <= pipmd_pkg::DRV_COAST;
          res_status <= pipmd_pkg::RS_RUNNING;
        end
        pipmd_pkg::DEC_BRAKE_STEP: begin
          res_drive  <= (left_dec == '0) ? pipmd_pkg::DRV_COAST : pipmd_pkg::DRV_BRAKE;
          res_status <= (left_dec == '0) ? pipmd_pkg::RS_DONE : pipmd_pkg::RS_BRAKING;
        end
        pipmd_pkg::DEC_IDLE: begin
          res_drive  <= pipmd_pkg::DRV_COAST;
          res_status <= pipmd_pkg::RS_IDLE;
        end
        pipmd_pkg::DEC_TIMEOUT: begin
          res_drive  <= pipmd_pkg::DRV_COAST;
          res_status <= pipmd_pkg::RS_TIMEOUT;
        end
        pipmd_pkg::DEC_ARRIVE: begin
          res_drive  <= (brake_ticks == '0) ? pipmd_pkg::DRV_COAST : pipmd_pkg::DRV_BRAKE;
          res_status <= (brake_ticks == '0) ? pipmd_pkg::RS_DONE : pipmd_pkg::RS_BRAKING;
        end
        default: begin
          res_drive  <= pipmd_pkg::DRV_COAST;
          res_status <= pipmd_pkg::RS_RUNNING;
        end
      endcase
    end
    if (cmd.mul_p) begin
      prod <= mul_out;
    end
    if (cmd.mul_i) begin
      acc  <= prod;
      prod <= mul_out;
    end
    if (cmd.acc_add) begin
      acc <= acc + prod;
    end
    if (cmd.div_step && (div_rem >= div_sub)) begin
      div_rem <= div_rem - div_sub;
      div_quo[cmd.div_idx] <= 1'b1;
    end
    if (cmd.duty) begin
      res_drive  <= acc[PROD_W-1] ? pipmd_pkg::DRV_REV : pipmd_pkg::DRV_FWD;
      res_duty   <= duty_val;
      res_status <= pipmd_pkg::RS_RUNNING;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {4'd0, 3'(res_status), res_duty, 2'(res_drive)};
    end
  end

  assign stat.drive_path = (dec == pipmd_pkg::DEC_DRIVE);
  assign stat.out_busy   = m_axis_tvalid && !m_axis_tready;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded over a waiting request");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    elapsed <= TIMEOUT_VAL)
    else $error("elapsed ticks past timeout");

  a_brake_left: assert property (@(posedge clk) disable iff (rst)
    (mode == pipmd_pkg::MODE_BRAKE) |-> (brake_left != '0))
    else $error("braking with no ticks left");

  a_duty_needs_drive: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[8:2] != '0)) |->
      (m_axis_tdata[1:0] == 2'(pipmd_pkg::DRV_FWD) ||
       m_axis_tdata[1:0] == 2'(pipmd_pkg::DRV_REV)))
    else $error("nonzero duty while coasting or braking");

endmodule

// ===== hw/rtl/pi_position_motor_drive_top.sv =====
// ----------------------------------------------------------------------------
// pi_position_motor_drive_top
// PI position controller with anti-windup clamp and soft-start duty ceiling.
// Every request gives exactly one result. A start request loads the target
// and begins a move; a tick request carries the encoder count and returns
// drive, duty and status. A tick that drives the motor runs through the single
// 33x25 gain multiplier, used once for each gain, and the 7-step soft-start ramp
// divider; start, idle, braking, arrival and timeout requests go from the
// decision step straight to the output register. A new request is taken
// once the previous one has been placed in the output register, even while
// that result still waits for the sink. Settings may be written whenever no
// request is in flight.
// ----------------------------------------------------------------------------
module pi_position_motor_drive_top #(
  parameter int unsigned TIMEOUT_TICKS = pipmd_pkg::TIMEOUT_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pipmd_pkg::IN_W-1:0]      s_axis_tdata,  // target[23:0], count[47:24]
  input  logic                            s_axis_tuser,  // kind[0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pipmd_pkg::OUT_W-1:0]     m_axis_tdata,  // drive[1:0], duty[8:2], status[11:9]
  input  logic                            cfg_we,
  input  logic [pipmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pipmd_pkg::CFG_W-1:0]     cfg_data
);

  pipmd_pkg::cmd_t  cmd;
  pipmd_pkg::stat_t stat;

  pipmd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  pipmd_datapath #(
    .TIMEOUT_TICKS (TIMEOUT_TICKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_kind       (s_axis_tuser),
    .in_data       (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== tb/pi_position_motor_drive_top_test.sv =====
// ----------------------------------------------------------------------------
// pi_position_motor_drive_top_test
// Self-checking bench for the PI position motor drive. Start and tick requests
// go in on the slave stream, and each drive command coming out is checked
// against a cycle-free model of the controller: error integral with clamp,
// Q8.24 gains, soft-start ceiling, braking, arrival and timeout. Directed
// corner requests come first. Random moves then follow a crude motor that
// closes on its target, mixed with noise, over several register settings.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module pi_position_motor_drive_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int POS_MAX     = 8388607;
  localparam int POS_MIN     = -8388608;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    pipmd_pkg::drive_t                 drive;
    logic [pipmd_pkg::DUTY_W-1:0]      duty;
    pipmd_pkg::run_status_t            status;
  } drive_cmd_t;

  class drive_cmd_board;
    logic [pipmd_pkg::GAIN_W-1:0]  kp, ki;
    logic [pipmd_pkg::LIMIT_W-1:0] ilimit;
    logic [pipmd_pkg::DUTY_W-1:0]  min_d, max_d;
    logic [pipmd_pkg::SS_W-1:0]    ss_ticks;
    logic [pipmd_pkg::TOL_W-1:0]   tol;
    logic [pipmd_pkg::BRAKE_W-1:0] brake_n;
    pipmd_pkg::mode_t mode;
    int target, error_sum, elapsed, brake_left;
    drive_cmd_t expected_cmds[$];
    int errors, n_checked;
    int n_status[8];

    function new();
      kp = pipmd_pkg::KP_GAIN_RST;
      ki = pipmd_pkg::KI_GAIN_DT_RST;
      ilimit = pipmd_pkg::INTEGRAL_LIM_RST;
      min_d = pipmd_pkg::MIN_DUTY_RST;
      max_d = pipmd_pkg::MAX_DUTY_RST;
      ss_ticks = pipmd_pkg::SOFTSTART_RST;
      tol = pipmd_pkg::STOP_TOL_RST;
      brake_n = pipmd_pkg::BRAKE_TICKS_RST;
      mode = pipmd_pkg::MODE_IDLE;
      target = 0;
      error_sum = 0;
      elapsed = 0;
      brake_left = 0;
      errors = 0;
      n_checked = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void set_reg(pipmd_pkg::cfg_reg_t idx, logic [pipmd_pkg::CFG_W-1:0] v);
      case (idx)
        pipmd_pkg::REG_KP_GAIN:         kp = v;
        pipmd_pkg::REG_KI_GAIN_DT:      ki = v;
        pipmd_pkg::REG_INTEGRAL_LIMIT:  ilimit = v[pipmd_pkg::LIMIT_W-1:0];
        pipmd_pkg::REG_MIN_DUTY:        min_d = v[pipmd_pkg::DUTY_W-1:0];
        pipmd_pkg::REG_MAX_DUTY:        max_d = v[pipmd_pkg::DUTY_W-1:0];
        pipmd_pkg::REG_SOFTSTART_TICKS: ss_ticks = v[pipmd_pkg::SS_W-1:0];
        pipmd_pkg::REG_STOP_TOLERANCE:  tol = v[pipmd_pkg::TOL_W-1:0];
        pipmd_pkg::REG_BRAKE_TICKS:     brake_n = v[pipmd_pkg::BRAKE_W-1:0];
        default: ;
      endcase
    endfunction

    function drive_cmd_t cmd(pipmd_pkg::drive_t d, int duty, pipmd_pkg::run_status_t s);
      drive_cmd_t c;
      c.drive = d;
      c.duty = pipmd_pkg::DUTY_W'(duty);
      c.status = s;
      return c;
    endfunction

    function drive_cmd_t next_cmd(pipmd_pkg::kind_t kind,
                                  logic signed [pipmd_pkg::POS_W-1:0] tgt,
                                  logic signed [pipmd_pkg::POS_W-1:0] cnt);
      int err, mag_err, span, ceil_d, duty;
      longint sum, acc, umag, mag;
      if (kind == pipmd_pkg::KIND_START) begin
        target = tgt;
        error_sum = 0;
        elapsed = 0;
        brake_left = 0;
        mode = pipmd_pkg::MODE_RUN;
        return cmd(pipmd_pkg::DRV_COAST, 0, pipmd_pkg::RS_RUNNING);
      end
      if (mode == pipmd_pkg::MODE_BRAKE) begin
        if (brake_left > 0) brake_left--;
        if (brake_left == 0) begin
          mode = pipmd_pkg::MODE_IDLE;
          return cmd(pipmd_pkg::DRV_COAST, 0, pipmd_pkg::RS_DONE);
        end
        return cmd(pipmd_pkg::DRV_BRAKE, 0, pipmd_pkg::RS_BRAKING);
      end
      if (mode != pipmd_pkg::MODE_RUN) begin
        mode = pipmd_pkg::MODE_IDLE;
        return cmd(pipmd_pkg::DRV_COAST, 0, pipmd_pkg::RS_IDLE);
      end
      if (elapsed >= int'(pipmd_pkg::TIMEOUT_TICKS_DEF)) begin
        mode = pipmd_pkg::MODE_IDLE;
        return cmd(pipmd_pkg::DRV_COAST, 0, pipmd_pkg::RS_TIMEOUT);
      end
      err = target - int'(cnt);
      mag_err = (err < 0) ? -err : err;
      if (mag_err < int'(tol)) begin
        brake_left = brake_n;
        if (brake_left == 0) begin
          mode = pipmd_pkg::MODE_IDLE;
          return cmd(pipmd_pkg::DRV_COAST, 0, pipmd_pkg::RS_DONE);
        end
        mode = pipmd_pkg::MODE_BRAKE;
        return cmd(pipmd_pkg::DRV_BRAKE, 0, pipmd_pkg::RS_BRAKING);
      end
      // anti-windup clamp
      sum = longint'(error_sum) + longint'(err);
      if (sum > longint'(ilimit)) sum = longint'(ilimit);
      if (sum < -longint'(ilimit)) sum = -longint'(ilimit);
      error_sum = int'(sum);
      acc = longint'(kp) * longint'(err) + longint'(ki) * sum;
      umag = (acc < 0) ? -acc : acc;
      mag = umag >> pipmd_pkg::FRAC_W;
      // soft-start ceiling
      if (elapsed < int'(ss_ticks)) begin
        span = int'(max_d) - int'(min_d);
        ceil_d = int'(min_d) + (span * elapsed) / int'(ss_ticks);
      end else begin
        ceil_d = int'(max_d);
      end
      if (mag < longint'(min_d)) duty = int'(min_d);
      else if (mag > 127) duty = 127;
      else duty = int'(mag);
      if (duty > ceil_d) duty = ceil_d;
      elapsed++;
      return cmd((acc >= 0) ? pipmd_pkg::DRV_FWD : pipmd_pkg::DRV_REV, duty,
                 pipmd_pkg::RS_RUNNING);
    endfunction

    function void note_request(pipmd_pkg::kind_t kind,
                               logic signed [pipmd_pkg::POS_W-1:0] tgt,
                               logic signed [pipmd_pkg::POS_W-1:0] cnt);
      drive_cmd_t c;
      c = next_cmd(kind, tgt, cnt);
      expected_cmds.push_back(c);
      n_status[c.status]++;
    endfunction

    function void check_result(logic [pipmd_pkg::OUT_W-1:0] data);
      drive_cmd_t want;
      logic [1:0] got_drive;
      logic [pipmd_pkg::DUTY_W-1:0] got_duty;
      logic [2:0] got_status;
      got_drive = data[1:0];
      got_duty = data[8:2];
      got_status = data[11:9];
      if (expected_cmds.size() == 0) begin
        $error("unexpected result: drive %0d, duty %0d, status %0d",
               got_drive, got_duty, got_status);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      n_checked++;
      if (got_drive !== want.drive) begin
        $error("drive: expected %0d, got %0d", want.drive, got_drive);
        errors++;
      end
      if (got_duty !== want.duty) begin
        $error("duty: expected %0d, got %0d", want.duty, got_duty);
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got_status);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pipmd_pkg::IN_W-1:0]     s_axis_tdata = '0;   // target[23:0], count[47:24]
  logic                           s_axis_tuser = 1'b0; // kind[0]
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pipmd_pkg::OUT_W-1:0]    m_axis_tdata;  // drive[1:0], duty[8:2], status[11:9]
  logic                           cfg_we = 1'b0;
  logic [pipmd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pipmd_pkg::CFG_W-1:0]    cfg_data = '0;

  bit quiet = 1'b0;
  int n_sent = 0;
  int n_phases = 0;
  int unsigned cycle_count = 0;
  drive_cmd_board cmd_board = new();

  always #6 clk = ~clk;

  pi_position_motor_drive_top #(
    .TIMEOUT_TICKS(pipmd_pkg::TIMEOUT_TICKS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function int idle_cycles();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task send_request(pipmd_pkg::kind_t kind, logic [pipmd_pkg::POS_W-1:0] tgt,
                    logic [pipmd_pkg::POS_W-1:0] cnt);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {cnt, tgt};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    cmd_board.note_request(kind, tgt, cnt);
    n_sent++;
  endtask

  // unused field carries random bits
  task start_move(int tgt);
    send_request(pipmd_pkg::KIND_START, pipmd_pkg::POS_W'(tgt),
                 pipmd_pkg::POS_W'($urandom));
  endtask

  task send_tick(int pos);
    send_request(pipmd_pkg::KIND_TICK, pipmd_pkg::POS_W'($urandom),
                 pipmd_pkg::POS_W'(pos));
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (cmd_board.expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task put_reg(pipmd_pkg::cfg_reg_t idx, logic [pipmd_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    cmd_board.set_reg(idx, v);
  endtask

  task load_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] lim, logic [31:0] mn,
                     logic [31:0] mx, logic [31:0] ss, logic [31:0] tol, logic [31:0] brk);
    wait_drained();
    put_reg(pipmd_pkg::REG_KP_GAIN, kp);
    put_reg(pipmd_pkg::REG_KI_GAIN_DT, ki);
    put_reg(pipmd_pkg::REG_INTEGRAL_LIMIT, lim);
    put_reg(pipmd_pkg::REG_MIN_DUTY, mn);
    put_reg(pipmd_pkg::REG_MAX_DUTY, mx);
    put_reg(pipmd_pkg::REG_SOFTSTART_TICKS, ss);
    put_reg(pipmd_pkg::REG_STOP_TOLERANCE, tol);
    put_reg(pipmd_pkg::REG_BRAKE_TICKS, brk);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  task load_random_settings(bit no_arrival);
    logic [31:0] kp, ki, lim, mn, mx, ss, tol, brk;
    kp = $urandom >> $urandom_range(0, 31);
    ki = $urandom >> $urandom_range(8, 31);
    lim = $urandom_range(0, 1048575) >> $urandom_range(0, 19);
    mn = $urandom_range(0, 100);
    mx = $urandom_range(0, 100);
    ss = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 30);
    tol = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
    brk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    if (no_arrival) tol = 0;
    load_settings(kp, ki, lim, mn, mx, ss, tol, brk);
  endtask

  // crude motor closing on the target, with noise requests and cut-off moves
  task run_move();
    int r, tgt, pos, cap, n;
    logic signed [pipmd_pkg::POS_W-1:0] t24;
    r = $urandom_range(0, 9);
    quiet = ($urandom_range(0, 7) == 0);
    if (r == 0) begin
      send_request(pipmd_pkg::kind_t'($urandom_range(0, 1)), pipmd_pkg::POS_W'($urandom),
                   pipmd_pkg::POS_W'($urandom));
      return;
    end
    t24 = pipmd_pkg::POS_W'($urandom);
    tgt = (r == 1) ? int'(t24) : int'($urandom_range(0, 40000)) - 20000;
    start_move(tgt);
    pos = 0;
    cap = $urandom_range(5, 70);
    n = 0;
    while (n < cap && cmd_board.mode != pipmd_pkg::MODE_IDLE) begin
      send_tick(pos);
      n++;
      pos = pos + (tgt - pos) / int'($urandom_range(2, 6)) + int'($urandom_range(0, 20)) - 10;
      if (pos > POS_MAX) pos = POS_MAX;
      if (pos < POS_MIN) pos = POS_MIN;
      if ($urandom_range(0, 39) == 0) break;
    end
    repeat ($urandom_range(0, 2)) send_tick(int'($urandom_range(0, 2000)) - 1000);
  endtask

  initial begin : stimulus
    int p, stop_at;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle tick, full-scale errors, arrival, restarts
    send_tick(POS_MAX);
    start_move(POS_MAX);
    send_tick(POS_MIN);
    send_tick(POS_MIN);
    start_move(POS_MIN);
    send_tick(POS_MAX);
    start_move(0);
    send_tick(0);
    send_tick(3);
    start_move(100);
    send_tick(100);

    // max gains and limit, no ramp, no tolerance
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1048575, 0, 100, 0, 0, 0);
    start_move(POS_MAX);
    send_tick(POS_MIN);
    send_tick(POS_MIN);
    send_tick(POS_MAX);

    // zero gains, downward ramp, arrival with no braking
    load_settings(0, 0, 0, 60, 20, 4, 10, 0);
    start_move(1000);
    send_tick(0);
    send_tick(0);
    send_tick(0);
    send_tick(995);
    send_tick(0);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(pipmd_pkg::KP_GAIN_RST, pipmd_pkg::KI_GAIN_DT_RST,
                         pipmd_pkg::INTEGRAL_LIM_RST, pipmd_pkg::MIN_DUTY_RST,
                         pipmd_pkg::MAX_DUTY_RST, pipmd_pkg::SOFTSTART_RST,
                         pipmd_pkg::STOP_TOL_RST, pipmd_pkg::BRAKE_TICKS_RST);
        1: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1048575, 0, 100, 1023, 65535, 255);
        2: load_settings(0, 0, 0, 0, 0, 1, 0, 0);
        3: load_random_settings(1'b1);
        default: load_random_settings(1'b0);
      endcase
      stop_at = n_sent + PHASE_ITEMS;
      while (n_sent < stop_at) run_move();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d register settings, %0d results checked",
             n_sent, n_phases, cmd_board.n_checked);
    $display("outcomes: %0d braking, %0d done, %0d timeout, %0d idle ticks",
             cmd_board.n_status[pipmd_pkg::RS_BRAKING], cmd_board.n_status[pipmd_pkg::RS_DONE],
             cmd_board.n_status[pipmd_pkg::RS_TIMEOUT], cmd_board.n_status[pipmd_pkg::RS_IDLE]);
    if (cmd_board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      cmd_board.check_result(m_axis_tdata);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
